/* src/block_sad_map_4x4_macros.svh */
// ---------------------------------------------------------------------------
// Block SAD assertion macros
// Shared concurrent assertion wrappers for the block SAD checker.
// ---------------------------------------------------------------------------
`ifndef BLOCK_SAD_MAP_4X4_MACROS_SVH
`define BLOCK_SAD_MAP_4X4_MACROS_SVH

// Checked only while reset is released.
`define BSAD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("block SAD check failed");

// Checked at every edge, reset included.
`define BSAD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("block SAD reset check failed");

`endif

/* src/bsad_pkg.sv */
// ---------------------------------------------------------------------------
// Block SAD package
// Widths, limits, register indexes and shared types of the block SAD map.
// ---------------------------------------------------------------------------
package bsad_pkg;

  localparam int LANES          = 4;
  localparam int BYTES_PER_LANE = 4;
  localparam int LANE_W         = 8 * BYTES_PER_LANE;
  localparam int LANE_SUM_W     = 10;
  localparam int ROW_SUM_W      = 12;
  localparam int SAD_W          = 14;
  localparam int MEAN_W         = 8;
  localparam int FRAME_W        = 32;
  localparam int SEG_W          = 64;

  localparam int BPR_W          = 9;
  localparam int BROWS_W        = 13;
  localparam int BRC_W          = 12;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 13;

  localparam int MAX_BLOCKS_PER_ROW_DEF = 256;
  localparam int MAX_BLOCK_ROWS         = 4096;

  typedef logic [LANE_SUM_W-1:0] lane_sum_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCKS_PER_ROW = 2'd0,
    REG_BLOCK_ROWS     = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic use_partial;
    logic emit;
    logic done;
  } bsad_ctrl_t;

endpackage

/* src/bsad_lane.sv */
// ---------------------------------------------------------------------------
// Block SAD lane
// Sum of absolute differences over the four bytes of one RGBA pixel.
// ---------------------------------------------------------------------------
module bsad_lane (
  input  logic [bsad_pkg::LANE_W-1:0] prev_px,
  input  logic [bsad_pkg::LANE_W-1:0] cur_px,
  output bsad_pkg::lane_sum_t         lane_sum
);
  import bsad_pkg::*;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    lane_sum = '0;
    for (int i = 0; i < BYTES_PER_LANE; i++) begin
      lane_sum = lane_sum + LANE_SUM_W'(abs_diff(prev_px[8*i +: 8], cur_px[8*i +: 8]));
    end
  end

endmodule

/* src/bsad_merge.sv */
// ---------------------------------------------------------------------------
// Block SAD merge
// Adds the lane sums of one row segment to the stored partial block sum and derives the mean, saturated at 255.
// ---------------------------------------------------------------------------
module bsad_merge (
  input  bsad_pkg::lane_sum_t [bsad_pkg::LANES-1:0] lane_sums,
  input  logic                                      use_partial,
  input  logic [bsad_pkg::SAD_W-1:0]                partial,
  output logic [bsad_pkg::SAD_W-1:0]                acc,
  output logic [bsad_pkg::MEAN_W-1:0]               mean
);
  import bsad_pkg::*;

  logic [ROW_SUM_W-1:0] row_sad;
  logic [SAD_W-1:0]     base;
  logic [SAD_W-5:0]     shifted;

  always_comb begin
    row_sad = '0;
    for (int l = 0; l < LANES; l++) begin
      row_sad = row_sad + ROW_SUM_W'(lane_sums[l]);
    end
  end

  assign base    = use_partial ? partial : '0;
  assign acc     = base + SAD_W'(row_sad);
  assign shifted = acc[SAD_W-1:4];
  assign mean    = (shifted > (SAD_W-4)'(255)) ? MEAN_W'(255) : shifted[MEAN_W-1:0];

endmodule

/* src/bsad_line.sv */
// ---------------------------------------------------------------------------
// Block SAD line store
// Partial block sums per block column, with write-to-read forwarding.
// ---------------------------------------------------------------------------
module bsad_line #(
  parameter int DEPTH = bsad_pkg::MAX_BLOCKS_PER_ROW_DEF,
  parameter int AW    = 8
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [bsad_pkg::SAD_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [bsad_pkg::SAD_W-1:0] rd_data
);
  import bsad_pkg::*;

  logic [SAD_W-1:0] mem [DEPTH];
  logic [SAD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/block_sad_map_4x4.sv */
// ---------------------------------------------------------------------------
// Block SAD map, 4x4 blocks
// Streams RGBA row segments of two frames and reports 4x4 block SADs.
// ---------------------------------------------------------------------------
// The block takes one 16-byte segment pair per clock cycle, sustained, and
// delivers a block result once the fourth-row beat of a block has passed
// the stage 1 and output registers. Four pixel lanes form the row SAD, a
// merge stage adds the partial sum read from the line store, and the single
// read and write port of that store sets the rate of one segment per cycle.
// Input stalls only while a finished result waits at a stalled output.
// Configuration takes effect for the next segment and belongs between frames.
module block_sad_map_4x4 #(
  parameter int MAX_BLOCKS_PER_ROW = bsad_pkg::MAX_BLOCKS_PER_ROW_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bsad_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bsad_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [bsad_pkg::SEG_W-1:0]       in_prev_low,
  input  logic [bsad_pkg::SEG_W-1:0]       in_prev_high,
  input  logic [bsad_pkg::SEG_W-1:0]       in_cur_low,
  input  logic [bsad_pkg::SEG_W-1:0]       in_cur_high,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bsad_pkg::MEAN_W-1:0]      out_block_mean,
  output logic [bsad_pkg::SAD_W-1:0]       out_block_sad,
  output logic [bsad_pkg::FRAME_W-1:0]     out_frame_sad,
  output logic                             out_frame_done
);
  import bsad_pkg::*;

  localparam int CW = $clog2(MAX_BLOCKS_PER_ROW > 1 ? MAX_BLOCKS_PER_ROW : 2);
  localparam int EW = ((CW > BPR_W) ? CW : BPR_W) + 1;

  logic [BPR_W-1:0]   bpr_r;
  logic [BROWS_W-1:0] brows_r;
  logic [CW-1:0]      col_r, col_nxt;
  logic [1:0]         rib_r, rib_nxt;
  logic [BRC_W-1:0]   brc_r, brc_nxt;
  logic [FRAME_W-1:0] frame_total_r;

  logic [EW-1:0]      bpr_eff;
  logic [BROWS_W-1:0] brows_eff;
  logic               last_col, last_brow;
  logic               in_accept;

  logic [2*SEG_W-1:0] prev_seg, cur_seg;
  lane_sum_t [LANES-1:0] lane_sums;
  lane_sum_t [LANES-1:0] lane_sums_r;

  logic               s1_valid_r;
  bsad_ctrl_t         s1_ctrl_r;
  logic [CW-1:0]      s1_addr_r;
  logic               s1_adv;

  logic [SAD_W-1:0]   partial;
  logic [SAD_W-1:0]   acc;
  logic [MEAN_W-1:0]  mean;
  logic [FRAME_W-1:0] frame_sum;

  logic               out_valid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpr_r   <= BPR_W'(1);
      brows_r <= BROWS_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BLOCKS_PER_ROW: bpr_r   <= cfg_data[BPR_W-1:0];
        REG_BLOCK_ROWS:     brows_r <= cfg_data[BROWS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (bpr_r == '0) begin
      bpr_eff = EW'(1);
    end else if (EW'(bpr_r) > EW'(MAX_BLOCKS_PER_ROW)) begin
      bpr_eff = EW'(MAX_BLOCKS_PER_ROW);
    end else begin
      bpr_eff = EW'(bpr_r);
    end
    if (brows_r == '0) begin
      brows_eff = BROWS_W'(1);
    end else if (brows_r > BROWS_W'(MAX_BLOCK_ROWS)) begin
      brows_eff = BROWS_W'(MAX_BLOCK_ROWS);
    end else begin
      brows_eff = brows_r;
    end
  end

  assign last_col  = (EW'(col_r) + EW'(1)) >= bpr_eff;
  assign last_brow = (BROWS_W'(brc_r) + BROWS_W'(1)) >= brows_eff;

  assign s1_adv    = s1_valid_r && (!s1_ctrl_r.emit || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    col_nxt = col_r;
    rib_nxt = rib_r;
    brc_nxt = brc_r;
    if (last_col) begin
      col_nxt = '0;
      if (rib_r == 2'd3) begin
        rib_nxt = '0;
        brc_nxt = last_brow ? '0 : brc_r + BRC_W'(1);
      end else begin
        rib_nxt = rib_r + 2'd1;
      end
    end else begin
      col_nxt = col_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      rib_r <= '0;
      brc_r <= '0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      rib_r <= rib_nxt;
      brc_r <= brc_nxt;
    end
  end

  assign prev_seg = {in_prev_high, in_prev_low};
  assign cur_seg  = {in_cur_high, in_cur_low};

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    bsad_lane u_lane (
      .prev_px  (prev_seg[LANE_W*l +: LANE_W]),
      .cur_px   (cur_seg[LANE_W*l +: LANE_W]),
      .lane_sum (lane_sums[l])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      lane_sums_r           <= lane_sums;
      s1_addr_r             <= col_r;
      s1_ctrl_r.use_partial <= (rib_r != 2'd0);
      s1_ctrl_r.emit        <= (rib_r == 2'd3);
      s1_ctrl_r.done        <= last_col && last_brow;
    end
  end

  bsad_line #(
    .DEPTH (MAX_BLOCKS_PER_ROW),
    .AW    (CW)
  ) u_line (
    .clk     (clk),
    .wr_en   (s1_adv && !s1_ctrl_r.emit),
    .wr_addr (s1_addr_r),
    .wr_data (acc),
    .rd_en   (in_accept),
    .rd_addr (col_r),
    .rd_data (partial)
  );

  bsad_merge u_merge (
    .lane_sums   (lane_sums_r),
    .use_partial (s1_ctrl_r.use_partial),
    .partial     (partial),
    .acc         (acc),
    .mean        (mean)
  );

  assign frame_sum = frame_total_r + FRAME_W'(acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_total_r <= '0;
    end else if (s1_adv && s1_ctrl_r.emit) begin
      frame_total_r <= s1_ctrl_r.done ? '0 : frame_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_ctrl_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_ctrl_r.emit) begin
      out_block_mean <= mean;
      out_block_sad  <= acc;
      out_frame_sad  <= frame_sum;
      out_frame_done <= s1_ctrl_r.done;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* src/bsad_check.sv */
// ---------------------------------------------------------------------------
// Block SAD port checker
// Watches the ports of the block SAD map and is bound to its top level.
// ---------------------------------------------------------------------------
`include "block_sad_map_4x4_macros.svh"

module bsad_check (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [bsad_pkg::MEAN_W-1:0]  out_block_mean,
  input logic [bsad_pkg::SAD_W-1:0]   out_block_sad,
  input logic [bsad_pkg::FRAME_W-1:0] out_frame_sad,
  input logic                         out_frame_done
);
  import bsad_pkg::*;

  logic [MEAN_W+SAD_W+FRAME_W:0] payload;
  logic [MEAN_W-1:0]             mean_exp;

  assign payload  = {out_block_mean, out_block_sad, out_frame_sad, out_frame_done};
  assign mean_exp = (out_block_sad[SAD_W-1:12] != '0) ? MEAN_W'(255) : out_block_sad[11:4];

  // A result beat that is held back keeps its payload.
  `BSAD_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(payload))

  // Input is held back only behind a waiting result.
  `BSAD_ASSERT(a_stall_cause, clk, rst_n, in_stall |-> out_valid && out_stall)

  // The mean follows the SAD of the same beat.
  `BSAD_ASSERT(a_mean, clk, rst_n, out_valid |-> out_block_mean == mean_exp)

  // Reset leaves no result pending.
  `BSAD_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid)

endmodule

bind block_sad_map_4x4 bsad_check u_bsad_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_block_mean (out_block_mean),
  .out_block_sad  (out_block_sad),
  .out_frame_sad  (out_frame_sad),
  .out_frame_done (out_frame_done)
);
